/* rtl/core/text_terminal_char_writer_macros.svh */
// Assertion macros for the text terminal character writer.
// Users provide signals clk and rst in the including scope.
`ifndef TEXT_TERMINAL_CHAR_WRITER_MACROS_SVH
`define TEXT_TERMINAL_CHAR_WRITER_MACROS_SVH

// Concurrent check on the rising edge of clk, off while rst is high
`define TTCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Same check, for a plain condition that must hold at every edge
`define TTCW_ASSERT_ALWAYS(label, cond, msg) \
  `TTCW_ASSERT(label, (cond), msg)

`endif

/* rtl/core/ttcw_pkg.sv */
// Shared types and constants of the text terminal character writer.
// No dependencies; imported by the interfaces, the RAM and the top level.
package ttcw_pkg;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int CELL_DATA_W = CHAR_W + COLOR_W;
  localparam int ADDR_W      = 11;
  localparam int OUT_ROW_W   = 5;
  localparam int OUT_COL_W   = 7;

  // Register port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  // Default geometry
  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STEP = 4;

  // Operations
  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT,
    ST_SCROLL,
    ST_BLANK
  } ttcw_state_t;

endpackage

/* rtl/core/ttcw_if.sv */
// Request and response channels of the text terminal character writer.
// Depends on ttcw_pkg for field widths.
interface ttcw_req_if import ttcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_address;

  modport source (output valid, op, char_code, cell_address, input ready);
  modport sink   (input valid, op, char_code, cell_address, output ready);
endinterface

interface ttcw_rsp_if import ttcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    cell_char;
  logic [COLOR_W-1:0]   cell_color;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic [OUT_COL_W-1:0] cursor_column;
  logic [ADDR_W-1:0]    cursor_index;

  modport source (output valid, cell_char, cell_color, cursor_row, cursor_column,
                  cursor_index, input ready);
  modport sink   (input valid, cell_char, cell_color, cursor_row, cursor_column,
                  cursor_index, output ready);
endinterface

/* rtl/core/ttcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on ttcw_pkg for default sizes.
module ttcw_ram import ttcw_pkg::*; #(
  parameter int WIDTH = CELL_DATA_W,
  parameter int DEPTH = DEF_ROWS * DEF_COLUMNS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/text_terminal_char_writer.sv */
// Text terminal character writer: prints bytes into a ROWS x COLUMNS cell RAM or reads a cell.
// Reads and non-scrolling prints go from accept to the EMIT state, which loads the output register once it is free.
// A print that scrolls first passes through SCROLL (copy each row one up) and BLANK (blank the bottom row).
// One word in flight; the next is taken once the result is registered.
// Reset (synchronous, rst high) runs a clearing pass over every cell of the cell
// RAM with req.ready low; register writes are taken throughout.
module text_terminal_char_writer import ttcw_pkg::*; #(
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ROWS     = DEF_ROWS,
  parameter int TAB_STEP = DEF_TAB_STEP
) (
  input  logic                  clk,
  input  logic                  rst,
  ttcw_req_if.sink              req,
  ttcw_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "text_terminal_char_writer_macros.svh"

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  ttcw_state_t state, state_next;

  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  column, column_next;
  logic [CELL_W-1:0] cnt, cnt_next;
  logic              copy_pend, copy_pend_next;
  logic              rd_hit, rd_hit_next;
  logic [COLOR_W-1:0] text_color;

  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic [COLOR_W-1:0]     out_color;
  logic [OUT_ROW_W-1:0]   out_row;
  logic [OUT_COL_W-1:0]   out_column;
  logic [ADDR_W-1:0]      out_index;
  logic                   load_out;

  logic                   ram_we, ram_re;
  logic [CELL_W-1:0]      ram_waddr, ram_raddr;
  logic [CELL_DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CELL_W-1:0] cur_idx;
  logic [COL_W:0]    col_inc;
  logic [COL_W+4:0]  col_tab;
  logic              last_row, last_col, in_range, scroll_start;

  // Register port: one register, no wait states
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_TEXT_COLOR) ? APB_DATA_W'(text_color) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_TEXT_COLOR) begin
      text_color <= pwdata[COLOR_W-1:0];
    end
  end

  // Cell RAM
  ttcw_ram #(
    .WIDTH (CELL_DATA_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cursor arithmetic: linear index and column steps
  assign cur_idx  = CELL_W'(CELL_W'(row) * CELL_W'(COLUMNS)) + CELL_W'(column);
  assign col_inc  = (COL_W+1)'(column) + (COL_W+1)'(1);
  assign col_tab  = (COL_W+5)'(column) + (COL_W+5)'(TAB_STEP);
  assign last_row = (row == ROW_W'(ROWS - 1));
  assign last_col = (column == COL_W'(COLUMNS - 1));
  assign in_range = (32'(req.cell_address) < CELLS);

  assign req.ready = (state == ST_IDLE);

  // Sequencer: next state, cursor update and RAM control
  always_comb begin
    state_next     = state;
    row_next       = row;
    column_next    = column;
    cnt_next       = cnt;
    copy_pend_next = 1'b0;
    rd_hit_next    = rd_hit;
    scroll_start   = 1'b0;
    load_out       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cur_idx;
    ram_wdata      = {text_color, CODE_SPACE};
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = {RESET_COLOR, CODE_SPACE};
        if (cnt == CELL_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + CELL_W'(1);
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          state_next  = ST_EMIT;
          rd_hit_next = 1'b0;
          if (req.op == OP_READ) begin
            rd_hit_next = in_range;
            ram_re      = in_range;
            ram_raddr   = CELL_W'(req.cell_address);
          end else begin
            unique case (req.char_code)
              CODE_NEWLINE: begin
                column_next = '0;
                if (last_row) begin
                  scroll_start = 1'b1;
                end else begin
                  row_next = row + ROW_W'(1);
                end
              end
              CODE_BACKSPACE: begin
                // one cell back in linear order; stays put at the origin
                ram_we = 1'b1;
                if (column != '0) begin
                  column_next = column - COL_W'(1);
                  ram_waddr   = cur_idx - CELL_W'(1);
                end else if (row != '0) begin
                  row_next    = row - ROW_W'(1);
                  column_next = COL_W'(COLUMNS - 1);
                  ram_waddr   = cur_idx - CELL_W'(1);
                end
              end
              CODE_TAB: begin
                if (32'(col_tab) >= COLUMNS) begin
                  column_next = COL_W'(COLUMNS - 1);
                end else begin
                  column_next = col_tab[COL_W-1:0];
                end
              end
              CODE_RETURN: begin
                column_next = '0;
              end
              default: begin
                ram_we    = 1'b1;
                ram_wdata = {text_color, req.char_code};
                if (last_col) begin
                  column_next = '0;
                  if (last_row) begin
                    scroll_start = 1'b1;
                  end else begin
                    row_next = row + ROW_W'(1);
                  end
                end else begin
                  column_next = col_inc[COL_W-1:0];
                end
              end
            endcase
          end
          if (scroll_start) begin
            state_next = ST_SCROLL;
            cnt_next   = '0;
          end
        end
      end

      ST_SCROLL: begin
        // read row below, write the word read last cycle one row up
        if (cnt != CELL_W'(CELLS - COLUMNS)) begin
          ram_re         = 1'b1;
          ram_raddr      = cnt + CELL_W'(COLUMNS);
          copy_pend_next = 1'b1;
          cnt_next       = cnt + CELL_W'(1);
        end else begin
          state_next = ST_BLANK;
        end
        if (copy_pend) begin
          ram_we    = 1'b1;
          ram_waddr = cnt - CELL_W'(1);
          ram_wdata = ram_rdata;
        end
      end

      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        if (cnt == CELL_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + CELL_W'(1);
        end
      end

      ST_EMIT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      row       <= '0;
      column    <= '0;
      cnt       <= '0;
      copy_pend <= 1'b0;
      rd_hit    <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      column    <= column_next;
      cnt       <= cnt_next;
      copy_pend <= copy_pend_next;
      rd_hit    <= rd_hit_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char   <= rd_hit ? ram_rdata[CHAR_W-1:0] : '0;
      out_color  <= rd_hit ? ram_rdata[CELL_DATA_W-1:CHAR_W] : '0;
      out_row    <= OUT_ROW_W'(row);
      out_column <= OUT_COL_W'(column);
      out_index  <= ADDR_W'(cur_idx);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.cell_char     = out_char;
  assign rsp.cell_color    = out_color;
  assign rsp.cursor_row    = out_row;
  assign rsp.cursor_column = out_column;
  assign rsp.cursor_index  = out_index;

  // Checks
  `TTCW_ASSERT_ALWAYS(a_cursor_in_screen,
    (32'(row) < ROWS) && (32'(column) < COLUMNS), "cursor outside screen")
  `TTCW_ASSERT(a_accept_leaves_idle,
    (req.valid && req.ready) |=> (state != ST_IDLE), "accepted word left sequencer idle")
  `TTCW_ASSERT(a_no_stray_write,
    (state == ST_IDLE && !req.valid) |-> !ram_we, "cell write without a word")
  `TTCW_ASSERT(a_scroll_write_behind,
    (state == ST_SCROLL && ram_we) |-> (32'(ram_waddr) < CELLS - COLUMNS),
    "scroll copy wrote into bottom row")
  `TTCW_ASSERT(a_scroll_cursor,
    (state == ST_SCROLL) |-> (last_row && column == '0), "cursor moved during scroll")

endmodule

/* bench/tb_text_terminal_char_writer.sv */
// Self-checking bench for text_terminal_char_writer: prints bytes and reads cells back,
// predicting every response word from a local screen model. Needs ttcw_pkg, the channel
// interfaces, the RAM and the writer RTL with its macro header.
`timescale 1ns / 100ps

module tb_text_terminal_char_writer import ttcw_pkg::*; ();

  localparam int COLS       = DEF_COLUMNS;
  localparam int ROW_COUNT  = DEF_ROWS;
  localparam int TAB        = DEF_TAB_STEP;
  localparam int CELL_COUNT = COLS * ROW_COUNT;
  localparam logic [PADDR_W-1:0] TEXT_COLOR_ADDR = PADDR_W'({REG_TEXT_COLOR, 2'b00});

  // One response word as the block reports it
  typedef struct packed {
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_color;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_column;
    logic [ADDR_W-1:0]    cursor_index;
  } cell_report_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ttcw_req_if req_ch ();
  ttcw_rsp_if rsp_ch ();

  text_terminal_char_writer dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Screen model and cursor
  logic [CELL_DATA_W-1:0] screen_model [CELL_COUNT];
  int                     cur_row;
  int                     cur_col;
  logic [COLOR_W-1:0]     color_model;

  cell_report_t pending_reports[$];
  int           error_count;
  int           words_sent;
  bit           tx_gaps;
  bit           rx_gaps;
  bit           hold_request;
  int           hold_len;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #200_000_000;
    $display("text_terminal_char_writer test failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Cursor to the next line; scroll when already on the bottom row
  function automatic void advance_row();
    cur_col = 0;
    if (cur_row + 1 >= ROW_COUNT) begin
      for (int i = 0; i < CELL_COUNT - COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
        screen_model[i] = {color_model, CODE_SPACE};
      cur_row = ROW_COUNT - 1;
    end else begin
      cur_row++;
    end
  endfunction

  // Apply one word to the screen model and return the expected response
  function automatic cell_report_t predict_console(logic op, logic [CHAR_W-1:0] ch,
                                                   logic [ADDR_W-1:0] addr);
    cell_report_t rep;
    rep = '0;
    if (op == OP_PRINT) begin
      case (ch)
        CODE_NEWLINE: advance_row();
        CODE_BACKSPACE: begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end
          screen_model[cur_row * COLS + cur_col] = {color_model, CODE_SPACE};
        end
        CODE_TAB: cur_col = (cur_col + TAB >= COLS) ? COLS - 1 : cur_col + TAB;
        CODE_RETURN: cur_col = 0;
        default: begin
          screen_model[cur_row * COLS + cur_col] = {color_model, ch};
          cur_col++;
          if (cur_col >= COLS) advance_row();
        end
      endcase
    end else if (addr < CELL_COUNT) begin
      rep.cell_char  = screen_model[addr][CHAR_W-1:0];
      rep.cell_color = screen_model[addr][CELL_DATA_W-1:CHAR_W];
    end
    rep.cursor_row    = OUT_ROW_W'(cur_row);
    rep.cursor_column = OUT_COL_W'(cur_col);
    rep.cursor_index  = ADDR_W'(cur_row * COLS + cur_col);
    return rep;
  endfunction

  // Offer one word, wait for the handshake, then record the prediction
  task automatic send_word(logic op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.char_code    <= ch;
    req_ch.cell_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    pending_reports.push_back(predict_console(op, ch, addr));
    words_sent++;
  endtask

  task automatic print_byte(logic [CHAR_W-1:0] ch);
    send_word(OP_PRINT, ch, ADDR_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(logic [ADDR_W-1:0] addr);
    send_word(OP_READ, CHAR_W'($urandom_range(0, 255)), addr);
  endtask

  // Stop offering and wait for every outstanding response
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, then read back
  task automatic write_text_color(logic [COLOR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TEXT_COLOR_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    color_model = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COLOR_W-1:0] !== value) begin
      $error("text_color readback: expected %02h, got %02h", value, prdata[COLOR_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Response sink with random stalls and on-demand long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        stall_left   = hold_len;
        hold_request = 1'b0;
      end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each response word with the oldest prediction
  always @(posedge clk) begin
    cell_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("response word with nothing expected");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (rsp_ch.cell_char !== want.cell_char) begin
          $error("cell_char: expected %02h, got %02h", want.cell_char, rsp_ch.cell_char);
          error_count++;
        end
        if (rsp_ch.cell_color !== want.cell_color) begin
          $error("cell_color: expected %02h, got %02h", want.cell_color, rsp_ch.cell_color);
          error_count++;
        end
        if (rsp_ch.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp_ch.cursor_row);
          error_count++;
        end
        if (rsp_ch.cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d",
                 want.cursor_column, rsp_ch.cursor_column);
          error_count++;
        end
        if (rsp_ch.cursor_index !== want.cursor_index) begin
          $error("cursor_index: expected %0d, got %0d",
                 want.cursor_index, rsp_ch.cursor_index);
          error_count++;
        end
      end
    end
  end

  // Fresh screen: blanks in the reset color, reads past the end give zero
  task automatic test_reset_screen();
    read_cell(ADDR_W'(0));
    read_cell(ADDR_W'(CELL_COUNT - 1));
    read_cell(ADDR_W'(CELL_COUNT));
    read_cell(ADDR_W'(2047));
  endtask

  // Control codes at the screen edges
  task automatic test_control_codes();
    print_byte("A");
    print_byte(CODE_BACKSPACE);          // back to origin, blanks it
    print_byte(CODE_BACKSPACE);          // at origin: stays
    read_cell(ADDR_W'(0));
    print_byte(CODE_TAB);
    print_byte(CODE_TAB);
    print_byte(CODE_RETURN);
    print_byte(CODE_NEWLINE);
    print_byte(CODE_BACKSPACE);          // column 0: up to end of previous row
    print_byte(CODE_TAB);                // clamps at last column
    print_byte("Z");                     // last column: wraps to next row
    read_cell(ADDR_W'(COLS - 1));
    print_byte(8'h00);
    print_byte(8'hFF);
    read_cell(ADDR_W'(COLS));
    read_cell(ADDR_W'(COLS + 1));
    wait_drained();
  endtask

  // Random traffic: text lines, read bursts, and raw byte noise
  task automatic run_traffic(int n_words);
    int target;
    int unsigned kind;
    int len;
    int pos;
    target = words_sent + n_words;
    while (words_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(COLS - 2, COLS + 2)
                                          : $urandom_range(0, 40);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 4) print_byte(CODE_BACKSPACE);
          else if ($urandom_range(0, 99) < 3) print_byte(CODE_TAB);
          else print_byte(CHAR_W'($urandom_range(8'h20, 8'h7E)));
        end
        print_byte(($urandom_range(0, 99) < 80) ? CODE_NEWLINE : CODE_RETURN);
      end else if (kind < 82) begin
        repeat ($urandom_range(1, 6)) begin
          kind = $urandom_range(0, 99);
          if (kind < 60) begin
            read_cell(ADDR_W'($urandom_range(0, CELL_COUNT - 1)));
          end else if (kind < 88) begin
            pos = cur_row * COLS + cur_col - int'($urandom_range(0, 6));
            read_cell(ADDR_W'((pos < 0) ? 0 : pos));
          end else begin
            read_cell(ADDR_W'($urandom_range(CELL_COUNT, 2047)));
          end
        end
      end else begin
        repeat ($urandom_range(1, 8)) print_byte(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Several color settings, extremes included, with and without idling
  task automatic test_color_phases();
    logic [COLOR_W-1:0] colors [6];
    colors[0] = 8'h00;
    colors[1] = 8'hFF;
    colors[2] = COLOR_W'($urandom_range(0, 255));
    colors[3] = 8'h4F;
    colors[4] = COLOR_W'($urandom_range(0, 255));
    colors[5] = RESET_COLOR;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_text_color(colors[p]);
      tx_gaps = (p != 2);
      rx_gaps = (p != 2) && (p != 4);
      run_traffic(290);
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    wait_drained();
  endtask

  // Long receiver hold-off while words keep coming, then a full pause
  task automatic test_backpressure();
    tx_gaps      = 1'b0;
    hold_len     = 400;
    hold_request = 1'b1;
    repeat (30) begin
      if ($urandom_range(0, 3) == 0) read_cell(ADDR_W'($urandom_range(0, 2047)));
      else print_byte(CHAR_W'($urandom_range(0, 255)));
    end
    tx_gaps = 1'b1;
    wait_drained();
  endtask

  // Sequence
  initial begin
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {RESET_COLOR, CODE_SPACE};
    cur_row      = 0;
    cur_col      = 0;
    color_model  = RESET_COLOR;
    error_count  = 0;
    words_sent   = 0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    hold_request = 1'b0;
    hold_len     = 0;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_PRINT;
    req_ch.char_code    = '0;
    req_ch.cell_address = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_screen();
    test_control_codes();
    test_backpressure();
    test_color_phases();

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("text_terminal_char_writer test passed");
    end else begin
      $display("text_terminal_char_writer test failed");
    end
    $finish;
  end

endmodule
